// ===== rtl/afu_pkg.sv =====
// afu_pkg: shared constants, codes, state types and engine structs
// for the activation function unit; used by afu_engine and the top level by scoped name
`default_nettype none
package afu_pkg;

   localparam int ROW_MAX = 64;
   localparam int IDX_W   = $clog2(ROW_MAX);
   localparam int CNT_W   = $clog2(ROW_MAX + 1);

   localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;

   localparam logic [2:0] KIND_NONE    = 3'd0;
   localparam logic [2:0] KIND_RELU    = 3'd1;
   localparam logic [2:0] KIND_SIGMOID = 3'd2;
   localparam logic [2:0] KIND_TANH    = 3'd3;
   localparam logic [2:0] KIND_SOFTMAX = 3'd4;
   localparam logic [2:0] KIND_LEAKY   = 3'd5;

   localparam logic REG_KIND  = 1'b0;
   localparam logic REG_SLOPE = 1'b1;

   localparam logic [15:0] SLOPE_RESET = 16'd655;

   localparam logic [4:0] TAYLOR_TERMS = 5'd30;
   localparam logic [8:0] EXP_Q_MAX    = 9'd63;
   localparam logic [6:0] QUOT_STEPS   = 7'd64;
   localparam logic [6:0] RATIO_STEPS  = 7'd9;
   localparam logic [63:0] RATIO_FULL  = 64'd256;

   typedef enum logic {
      ENG_EXP,
      ENG_RATIO
   } eng_op_type;

   typedef enum logic [2:0] {
      G_IDLE,
      G_UMUL,
      G_UDIV,
      G_PMUL,
      G_RDIV
   } eng_state_type;

   typedef enum logic [3:0] {
      T_IDLE,
      T_OUT,
      T_SGEXP,
      T_SGRAT,
      T_MRD,
      T_MCMP,
      T_SRD,
      T_SEXP,
      T_ERD,
      T_EEXP,
      T_ERAT
   } top_state_type;

   typedef struct packed {
      logic        start;
      eng_op_type  op;
      logic [16:0] n;
      logic [63:0] num;
      logic [63:0] den;
   } eng_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] value;
   } eng_rsp_type;

endpackage
`default_nettype wire

// ===== rtl/afu_mul.sv =====
// afu_mul: (a * b) >> 62 over four 32x32 partial products, one per cycle
// depends on: nothing
`default_nettype none
module afu_mul (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] a,
   input  wire logic [63:0] b,
   output logic             done,
   output logic [63:0]      res
);

   logic [63:0]  a_ff, a_in, b_ff, b_in;
   logic [127:0] acc_ff, acc_in;
   logic [63:0]  pp_ff, pp_in;
   logic [1:0]   ppsh_ff, ppsh_in;
   logic [2:0]   step_ff, step_in;
   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [31:0]  ai, bi;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      ai      = step_ff[1] ? a_ff[63:32] : a_ff[31:0];
      bi      = step_ff[0] ? b_ff[63:32] : b_ff[31:0];
      pp_in   = ai * bi;
      ppsh_in = {1'b0, step_ff[1]} + {1'b0, step_ff[0]};
      if (start) begin
         a_in    = a;
         b_in    = b;
         acc_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (step_ff != 3'd0) begin
            acc_in = acc_ff + (128'(pp_ff) << {ppsh_ff, 5'b0});
         end
         step_in = step_ff + 3'd1;
         if (step_ff == 3'd4) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      acc_ff  <= acc_in;
      pp_ff   <= pp_in;
      ppsh_ff <= ppsh_in;
   end

   assign done = done_ff;
   assign res  = acc_ff[125:62];

endmodule
`default_nettype wire

// ===== rtl/afu_div.sv =====
// afu_div: restoring divider, one quotient bit per cycle
// depends on: nothing
`default_nettype none
module afu_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] rem0,
   input  wire logic [63:0] quo0,
   input  wire logic [63:0] dvs,
   input  wire logic [6:0]  steps,
   output logic             done,
   output logic [63:0]      quo
);

   logic [63:0] rem_ff, rem_in, quo_ff, quo_in, dvs_ff, dvs_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [64:0] r2, diff;
   logic        ge;

   always_comb begin
      r2      = {rem_ff, quo_ff[63]};
      diff    = r2 - {1'b0, dvs_ff};
      ge      = r2 >= {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = rem0;
         quo_in  = quo0;
         dvs_in  = dvs;
         cnt_in  = steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[63:0] : r2[63:0];
         quo_in = {quo_ff[62:0], ge};
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule
`default_nettype wire

// ===== rtl/afu_engine.sv =====
// afu_engine: sequencer for e^-(n/256) in q62 and round(256*num/den)
// depends on: afu_pkg, afu_mul, afu_div
`default_nettype none
module afu_engine (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire afu_pkg::eng_req_type req,
   output afu_pkg::eng_rsp_type     rsp
);

   afu_pkg::eng_state_type state_ff, state_in;
   logic [63:0] t_ff, t_in, term_ff, term_in, sum_ff, sum_in;
   logic [63:0] v_ff, v_in, e1_ff, e1_in, num_ff, num_in, den_ff, den_in;
   logic [63:0] val_ff, val_in;
   logic [4:0]  k_ff, k_in;
   logic [5:0]  q_ff, q_in;
   logic        pass_ff, pass_in, issued_ff, issued_in, done_ff, done_in;
   logic        mul_start, mul_done, div_start, div_done;
   logic [63:0] mul_a, mul_b, mul_res, div_rem0, div_quo0, div_dvs, div_quo;
   logic [6:0]  div_steps;
   logic [63:0] sum_next;

   afu_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .a(mul_a), .b(mul_b),
      .done(mul_done), .res(mul_res)
   );

   afu_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .rem0(div_rem0),
      .quo0(div_quo0), .dvs(div_dvs), .steps(div_steps), .done(div_done),
      .quo(div_quo)
   );

   always_comb begin
      state_in  = state_ff;
      t_in      = t_ff;
      term_in   = term_ff;
      sum_in    = sum_ff;
      v_in      = v_ff;
      e1_in     = e1_ff;
      num_in    = num_ff;
      den_in    = den_ff;
      val_in    = val_ff;
      k_in      = k_ff;
      q_in      = q_ff;
      pass_in   = pass_ff;
      issued_in = issued_ff;
      done_in   = 1'b0;
      mul_start = 1'b0;
      div_start = 1'b0;
      mul_a     = term_ff;
      mul_b     = t_ff;
      div_rem0  = '0;
      div_quo0  = mul_res;
      div_dvs   = {59'b0, k_ff};
      div_steps = afu_pkg::QUOT_STEPS;
      sum_next  = k_ff[0] ? (sum_ff - div_quo) : (sum_ff + div_quo);
      case (state_ff)
         afu_pkg::G_IDLE: begin
            issued_in = 1'b0;
            if (req.start) begin
               if (req.op == afu_pkg::ENG_EXP) begin
                  if (req.n[16:8] > afu_pkg::EXP_Q_MAX) begin
                     val_in  = '0;
                     done_in = 1'b1;
                  end else begin
                     t_in     = {2'b0, req.n[7:0], 54'b0};
                     term_in  = afu_pkg::ONE_Q62;
                     sum_in   = afu_pkg::ONE_Q62;
                     k_in     = 5'd1;
                     pass_in  = 1'b0;
                     q_in     = req.n[13:8];
                     state_in = afu_pkg::G_UMUL;
                  end
               end else begin
                  num_in = req.num;
                  den_in = req.den;
                  if (req.num >= req.den) begin
                     val_in  = afu_pkg::RATIO_FULL;
                     done_in = 1'b1;
                  end else begin
                     state_in = afu_pkg::G_RDIV;
                  end
               end
            end
         end
         afu_pkg::G_UMUL: begin
            mul_start = !issued_ff;
            issued_in = 1'b1;
            if (mul_done) begin
               issued_in = 1'b0;
               state_in  = afu_pkg::G_UDIV;
            end
         end
         afu_pkg::G_UDIV: begin
            div_start = !issued_ff;
            issued_in = 1'b1;
            if (div_done) begin
               issued_in = 1'b0;
               term_in   = div_quo;
               sum_in    = sum_next;
               k_in      = k_ff + 5'd1;
               state_in  = afu_pkg::G_UMUL;
               if (k_ff == afu_pkg::TAYLOR_TERMS) begin
                  if (!pass_ff) begin
                     v_in = sum_next;
                     if (q_ff == 6'd0) begin
                        val_in   = sum_next;
                        done_in  = 1'b1;
                        state_in = afu_pkg::G_IDLE;
                     end else begin
                        pass_in = 1'b1;
                        t_in    = afu_pkg::ONE_Q62;
                        term_in = afu_pkg::ONE_Q62;
                        sum_in  = afu_pkg::ONE_Q62;
                        k_in    = 5'd1;
                     end
                  end else begin
                     e1_in    = sum_next;
                     state_in = afu_pkg::G_PMUL;
                  end
               end
            end
         end
         afu_pkg::G_PMUL: begin
            mul_a     = v_ff;
            mul_b     = e1_ff;
            mul_start = !issued_ff;
            issued_in = 1'b1;
            if (mul_done) begin
               issued_in = 1'b0;
               v_in      = mul_res;
               q_in      = q_ff - 6'd1;
               if (q_ff == 6'd1) begin
                  val_in   = mul_res;
                  done_in  = 1'b1;
                  state_in = afu_pkg::G_IDLE;
               end
            end
         end
         afu_pkg::G_RDIV: begin
            div_rem0  = num_ff;
            div_quo0  = '0;
            div_dvs   = den_ff;
            div_steps = afu_pkg::RATIO_STEPS;
            div_start = !issued_ff;
            issued_in = 1'b1;
            if (div_done) begin
               issued_in = 1'b0;
               val_in    = {55'b0, div_quo[8:0]} + 64'd1 >> 1;
               done_in   = 1'b1;
               state_in  = afu_pkg::G_IDLE;
            end
         end
         default: begin
            state_in = afu_pkg::G_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= afu_pkg::G_IDLE;
         issued_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         issued_ff <= issued_in;
         done_ff   <= done_in;
      end
      t_ff    <= t_in;
      term_ff <= term_in;
      sum_ff  <= sum_in;
      v_ff    <= v_in;
      e1_ff   <= e1_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      val_ff  <= val_in;
      k_ff    <= k_in;
      q_ff    <= q_in;
      pass_ff <= pass_in;
   end

   assign rsp.done  = done_ff;
   assign rsp.value = val_ff;

endmodule
`default_nettype wire

// ===== rtl/activation_function_unit.sv =====
// activation_function_unit: top level, mode control, softmax row store
// depends on: afu_pkg, afu_engine (with afu_mul, afu_div)
//
//   channel | ports                                          | direction
//   req     | req_valid req_ready req_value req_row_end      | in
//   rsp     | rsp_valid rsp_ready rsp_result_value rsp_last  | out
//           | rsp_row_overflow                               |
//   csr     | csr_valid csr_ready csr_index csr_data         | in
//
// none, relu and leaky relu results are registered and sent from the output
// state; a softmax word without row end is held until its row ends. sigmoid and
// tanh take one exp (30 multiply-divide rounds, 30 more for e^-1 and one multiply
// per whole unit of the argument when that is nonzero) and a 9-step ratio division.
// a softmax row takes a max pass (read, compare per value) and two exp passes.
// reset is synchronous; no clearing pass. a stalled rsp holds the sequencer.
`default_nettype none
module activation_function_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [15:0] req_value,
   input  wire logic        req_row_end,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_result_value,
   output logic             rsp_last,
   output logic             rsp_row_overflow,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_data
);

   localparam int CW = afu_pkg::CNT_W;
   localparam int IW = afu_pkg::IDX_W;

   afu_pkg::top_state_type state_ff, state_in;
   logic [2:0]    kind_ff, kind_in;
   logic [15:0]   slope_ff, slope_in;
   logic [CW-1:0] cnt_ff, cnt_in, idx_ff, idx_in;
   logic          ovf_ff, ovf_in, issued_ff, issued_in;
   logic [15:0]   x_ff, x_in, max_ff, max_in, res_ff, res_in;
   logic          res_last_ff, res_last_in, res_ovf_ff, res_ovf_in;
   logic [63:0]   sum_ff, sum_in, e_ff, e_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   rsp_value_ff, rsp_value_in;
   logic          rsp_last_ff, rsp_last_in, rsp_ovf_ff, rsp_ovf_in;
   logic [15:0]   mem [afu_pkg::ROW_MAX];
   logic [15:0]   mem_q_ff;
   logic          mem_we;

   afu_pkg::eng_req_type ereq;
   afu_pkg::eng_rsp_type ersp;

   logic          slot_free;
   logic [15:0]   xmag, lk_res, ew_res;
   logic [32:0]   lk_prod;
   logic [16:0]   lk_mag, diff;
   logic [15:0]   rat16;

   afu_engine u_engine (
      .clock(clock), .reset(reset), .req(ereq), .rsp(ersp)
   );

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign xmag      = x_ff[15] ? (16'd0 - x_ff) : x_ff;
   assign diff      = {max_ff[15], max_ff} - {mem_q_ff[15], mem_q_ff};
   assign rat16     = {7'b0, ersp.value[8:0]};

   // elementwise result straight from the incoming word
   always_comb begin
      lk_prod = 33'({16'd0 - req_value}) * 33'(slope_ff) + 33'd32768;
      lk_mag  = lk_prod[32:16];
      lk_res  = req_value[15] ? 16'(17'd0 - lk_mag) : req_value;
      case (kind_ff)
         afu_pkg::KIND_RELU:  ew_res = req_value[15] ? 16'd0 : req_value;
         afu_pkg::KIND_LEAKY: ew_res = lk_res;
         default:             ew_res = req_value;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      slope_in     = slope_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      ovf_in       = ovf_ff;
      issued_in    = issued_ff;
      x_in         = x_ff;
      max_in       = max_ff;
      res_in       = res_ff;
      res_last_in  = res_last_ff;
      res_ovf_in   = res_ovf_ff;
      sum_in       = sum_ff;
      e_in         = e_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      mem_we       = 1'b0;
      req_ready    = 1'b0;
      ereq.start   = 1'b0;
      ereq.op      = afu_pkg::ENG_EXP;
      ereq.n       = diff;
      ereq.num     = e_ff;
      ereq.den     = sum_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         if (csr_index == afu_pkg::REG_KIND) begin
            kind_in = csr_data[2:0];
            cnt_in  = '0;
            ovf_in  = 1'b0;
         end else begin
            slope_in = csr_data;
         end
      end

      case (state_ff)
         afu_pkg::T_IDLE: begin
            req_ready = 1'b1;
            issued_in = 1'b0;
            if (req_valid) begin
               x_in        = req_value;
               res_in      = ew_res;
               res_last_in = 1'b1;
               res_ovf_in  = 1'b0;
               case (kind_ff)
                  afu_pkg::KIND_SOFTMAX: begin
                     if (cnt_ff < CW'(afu_pkg::ROW_MAX)) begin
                        mem_we = 1'b1;
                        cnt_in = cnt_ff + CW'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                     if (req_row_end) begin
                        idx_in   = '0;
                        state_in = afu_pkg::T_MRD;
                     end
                  end
                  afu_pkg::KIND_SIGMOID, afu_pkg::KIND_TANH: begin
                     state_in = afu_pkg::T_SGEXP;
                  end
                  default: begin
                     state_in = afu_pkg::T_OUT;
                  end
               endcase
            end
         end
         afu_pkg::T_OUT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_ff;
               rsp_last_in  = res_last_ff;
               rsp_ovf_in   = res_ovf_ff;
               state_in     = afu_pkg::T_IDLE;
               if (kind_ff == afu_pkg::KIND_SOFTMAX) begin
                  if (res_last_ff) begin
                     cnt_in = '0;
                     ovf_in = 1'b0;
                  end else begin
                     idx_in   = idx_ff + CW'(1);
                     state_in = afu_pkg::T_ERD;
                  end
               end
            end
         end
         afu_pkg::T_SGEXP: begin
            ereq.n     = (kind_ff == afu_pkg::KIND_TANH) ? {xmag, 1'b0} : {1'b0, xmag};
            ereq.start = !issued_ff;
            issued_in  = 1'b1;
            if (ersp.done) begin
               issued_in = 1'b0;
               e_in      = ersp.value;
               state_in  = afu_pkg::T_SGRAT;
            end
         end
         afu_pkg::T_SGRAT: begin
            ereq.op  = afu_pkg::ENG_RATIO;
            ereq.den = afu_pkg::ONE_Q62 + e_ff;
            if (kind_ff == afu_pkg::KIND_TANH) begin
               ereq.num = afu_pkg::ONE_Q62 - e_ff;
            end else begin
               ereq.num = x_ff[15] ? e_ff : afu_pkg::ONE_Q62;
            end
            ereq.start = !issued_ff;
            issued_in  = 1'b1;
            if (ersp.done) begin
               issued_in = 1'b0;
               res_in    = (kind_ff == afu_pkg::KIND_TANH && x_ff[15]) ?
                           (16'd0 - rat16) : rat16;
               state_in  = afu_pkg::T_OUT;
            end
         end
         afu_pkg::T_MRD: begin
            state_in = afu_pkg::T_MCMP;
         end
         afu_pkg::T_MCMP: begin
            if (idx_ff == '0 || $signed(mem_q_ff) > $signed(max_ff)) begin
               max_in = mem_q_ff;
            end
            if (idx_ff + CW'(1) == cnt_ff) begin
               idx_in   = '0;
               sum_in   = '0;
               state_in = afu_pkg::T_SRD;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = afu_pkg::T_MRD;
            end
         end
         afu_pkg::T_SRD: begin
            state_in = afu_pkg::T_SEXP;
         end
         afu_pkg::T_SEXP: begin
            ereq.start = !issued_ff;
            issued_in  = 1'b1;
            if (ersp.done) begin
               issued_in = 1'b0;
               sum_in    = sum_ff + {6'b0, ersp.value[63:6]};
               if (idx_ff + CW'(1) == cnt_ff) begin
                  idx_in = '0;
               end else begin
                  idx_in = idx_ff + CW'(1);
               end
               state_in = (idx_ff + CW'(1) == cnt_ff) ? afu_pkg::T_ERD : afu_pkg::T_SRD;
            end
         end
         afu_pkg::T_ERD: begin
            state_in = afu_pkg::T_EEXP;
         end
         afu_pkg::T_EEXP: begin
            ereq.start = !issued_ff;
            issued_in  = 1'b1;
            if (ersp.done) begin
               issued_in = 1'b0;
               e_in      = {6'b0, ersp.value[63:6]};
               state_in  = afu_pkg::T_ERAT;
            end
         end
         afu_pkg::T_ERAT: begin
            ereq.op    = afu_pkg::ENG_RATIO;
            ereq.start = !issued_ff;
            issued_in  = 1'b1;
            if (ersp.done) begin
               issued_in   = 1'b0;
               res_in      = rat16;
               res_last_in = (idx_ff + CW'(1) == cnt_ff);
               res_ovf_in  = ovf_ff;
               state_in    = afu_pkg::T_OUT;
            end
         end
         default: begin
            state_in = afu_pkg::T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= afu_pkg::T_IDLE;
         kind_ff      <= afu_pkg::KIND_NONE;
         slope_ff     <= afu_pkg::SLOPE_RESET;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         ovf_ff       <= 1'b0;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         slope_ff     <= slope_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         ovf_ff       <= ovf_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff         <= x_in;
      max_ff       <= max_in;
      res_ff       <= res_in;
      res_last_ff  <= res_last_in;
      res_ovf_ff   <= res_ovf_in;
      sum_ff       <= sum_in;
      e_ff         <= e_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   // row store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[cnt_ff[IW-1:0]] <= req_value;
      end
      mem_q_ff <= mem[idx_ff[IW-1:0]];
   end

   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_row_overflow = rsp_ovf_ff;

endmodule
`default_nettype wire

// ===== rtl/afu_checker.sv =====
// afu_checker: port-level checks on the activation function unit
// depends on: activation_function_unit (bound below)
`default_nettype none
module afu_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] rsp_result_value,
   input wire logic        rsp_last
);

   // a held word keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value))
      else $error("rsp word changed while stalled");

   // no new word taken while a softmax row is still being sent
   a_row_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("req taken during row emission");

   // reset leaves an empty output and a ready input
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("bad state after reset");

endmodule

bind activation_function_unit afu_checker u_afu_checker (
   .clock(clock), .reset(reset), .req_ready(req_ready), .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready), .rsp_result_value(rsp_result_value), .rsp_last(rsp_last)
);
`default_nettype wire

// ===== dv/tb_top.sv =====
// tb_top: self-checking testbench for activation_function_unit
// depends on afu_pkg and the rtl; a scoreboard class predicts every result word
// and checks it as it leaves the block
`default_nettype none
module tb_top;
   import afu_pkg::*;

   localparam logic [2:0] KIND_SPARE6 = 3'd6;
   localparam logic [2:0] KIND_SPARE7 = 3'd7;

   typedef struct {
      logic [15:0] value;
      logic        last;
      logic        overflow;
   } result_word_type;

   class activation_scoreboard;
      logic [2:0]   kind;
      logic [15:0]  slope;
      int           row[$];
      bit           overflow;
      result_word_type pending_q[$];
      int           errors;
      logic [63:0]  e_one;

      function new();
         kind = KIND_NONE;
         slope = SLOPE_RESET;
         overflow = 0;
         errors = 0;
         e_one = exp_unit(ONE_Q62);
      endfunction

      function logic [63:0] mul62(logic [63:0] a, logic [63:0] b);
         logic [127:0] p;
         p = {64'd0, a} * {64'd0, b};
         return p[125:62];
      endfunction

      // e^-t for t in [0,1], q62
      function logic [63:0] exp_unit(logic [63:0] t);
         logic [63:0] sum;
         logic [63:0] term;
         sum = ONE_Q62;
         term = ONE_Q62;
         for (int k = 1; k <= 30; k++) begin
            term = mul62(term, t) / 64'(k);
            if (k % 2 == 1) sum = sum - term;
            else sum = sum + term;
         end
         return sum;
      endfunction

      // e^-(n/256), q62
      function logic [63:0] exp_neg(int unsigned n);
         logic [63:0] v;
         if ((n >> 8) > 63) return 64'd0;
         v = exp_unit(64'(n & 255) << 54);
         for (int i = 0; i < int'(n >> 8); i++) v = mul62(v, e_one);
         return v;
      endfunction

      function int unsigned ratio256(logic [63:0] n, logic [63:0] d);
         logic [64:0] rem;
         int unsigned q;
         if (n >= d) return 256;
         rem = {1'b0, n};
         q = 0;
         for (int i = 0; i < 9; i++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= {1'b0, d}) begin
               rem = rem - {1'b0, d};
               q = q | 1;
            end
         end
         return (q + 1) >> 1;
      endfunction

      function void write_reg(logic idx, logic [15:0] d);
         if (idx == REG_KIND) begin
            kind = d[2:0];
            row.delete();
            overflow = 0;
         end else begin
            slope = d;
         end
      endfunction

      function void note_input(logic [15:0] v, logic row_end);
         int x;
         int unsigned mag;
         int r;
         int m;
         logic [63:0] ex[64];
         logic [63:0] sum;
         logic [63:0] e;
         result_word_type w;
         x = int'($signed(v));
         mag = (x < 0) ? -x : x;
         if (kind == KIND_SOFTMAX) begin
            if (row.size() < ROW_MAX) row.push_back(x);
            else overflow = 1;
            if (!row_end) return;
            m = row[0];
            foreach (row[i]) if (row[i] > m) m = row[i];
            sum = 0;
            foreach (row[i]) begin
               ex[i] = exp_neg(m - row[i]) >> 6;
               sum = sum + ex[i];
            end
            foreach (row[i]) begin
               w.value = 16'(ratio256(ex[i], sum));
               w.last = (i == row.size() - 1);
               w.overflow = overflow;
               pending_q.push_back(w);
            end
            row.delete();
            overflow = 0;
            return;
         end
         case (kind)
            KIND_RELU: r = (x > 0) ? x : 0;
            KIND_SIGMOID: begin
               e = exp_neg(mag);
               r = (x >= 0) ? ratio256(ONE_Q62, ONE_Q62 + e) : ratio256(e, ONE_Q62 + e);
            end
            KIND_TANH: begin
               e = exp_neg(mag * 2);
               r = ratio256(ONE_Q62 - e, ONE_Q62 + e);
               if (x < 0) r = -r;
            end
            KIND_LEAKY: r = (x >= 0) ? x : -int'((mag * slope + 32768) >> 16);
            default: r = x;
         endcase
         w.value = 16'(r);
         w.last = 1;
         w.overflow = 0;
         pending_q.push_back(w);
      endfunction

      task report(string s);
         $display("mismatch at %0t: %s", $realtime, s);
         errors++;
      endtask

      task check_result(logic [15:0] v, logic l, logic o);
         result_word_type w;
         if (pending_q.size() == 0) begin
            report($sformatf("unexpected word value %h", v));
            return;
         end
         w = pending_q.pop_front();
         if (v !== w.value) report($sformatf("value %h, want %h", v, w.value));
         if (l !== w.last) report($sformatf("last %b, want %b", l, w.last));
         if (o !== w.overflow) report($sformatf("row_overflow %b, want %b", o, w.overflow));
      endtask
   endclass

   logic clock, reset;
   logic req_valid, req_ready, req_row_end;
   logic [15:0] req_value;
   logic rsp_valid, rsp_ready, rsp_last, rsp_row_overflow;
   logic [15:0] rsp_result_value;
   logic csr_valid, csr_ready, csr_index;
   logic [15:0] csr_data;

   activation_scoreboard sb;
   bit quiet;

   activation_function_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_value(req_value), .req_row_end(req_row_end),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_result_value(rsp_result_value), .rsp_last(rsp_last),
      .rsp_row_overflow(rsp_row_overflow),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #400_000_000;
      $display("activation_function_unit verification failed");
      $finish;
   end

   initial begin
      rsp_ready <= 1'b1;
      forever begin
         repeat ($urandom_range(1, 40)) @(posedge clock);
         if (!quiet && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_result_value, rsp_last, rsp_row_overflow);
   end

   task send_word(logic [15:0] v, logic re);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      req_row_end <= re;
      do @(posedge clock); while (!req_ready);
      sb.note_input(v, re);
   endtask

   // drain all expected words, then let the block settle
   task drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending_q.size() != 0);
      repeat (50) @(posedge clock);
   endtask

   task write_reg(logic idx, logic [15:0] d);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= d;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.write_reg(idx, d);
   endtask

   initial begin
      logic [2:0] k;
      logic [15:0] v;
      sb = new();
      quiet = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_value <= '0;
      req_row_end <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= REG_KIND;
      csr_data <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes of each function
      send_word(16'h7fff, 1'b1);
      send_word(16'h8000, 1'b0);
      write_reg(REG_KIND, 16'(KIND_RELU));
      send_word(16'hffff, 1'b0);
      send_word(16'h7fff, 1'b1);
      write_reg(REG_KIND, 16'(KIND_SIGMOID));
      send_word(16'h0000, 1'b0);
      send_word(16'h8000, 1'b0);
      send_word(16'hff80, 1'b0);
      write_reg(REG_KIND, 16'(KIND_TANH));
      send_word(16'h7fff, 1'b0);
      send_word(16'h0100, 1'b0);
      send_word(16'hfe80, 1'b0);
      write_reg(REG_KIND, 16'(KIND_LEAKY));
      send_word(16'hffff, 1'b0);
      send_word(16'h8000, 1'b0);
      send_word(16'h0064, 1'b0);
      write_reg(REG_SLOPE, 16'hffff);
      send_word(16'h8000, 1'b0);
      send_word(16'hff7f, 1'b0);
      write_reg(REG_SLOPE, 16'h0000);
      send_word(16'hfed4, 1'b0);
      write_reg(REG_KIND, 16'(KIND_SPARE6));
      send_word(16'h8001, 1'b1);
      write_reg(REG_KIND, 16'(KIND_SPARE7));
      send_word(16'h1234, 1'b0);
      // softmax: one-word row, short row, partial row dropped by kind write
      write_reg(REG_KIND, 16'(KIND_SOFTMAX));
      send_word(16'h8000, 1'b1);
      send_word(16'h0100, 1'b0);
      send_word(16'hff00, 1'b0);
      send_word(16'h7fff, 1'b1);
      send_word(16'h0200, 1'b0);
      send_word(16'h0300, 1'b0);
      write_reg(REG_KIND, 16'(KIND_SOFTMAX));
      send_word(16'h0010, 1'b1);

      // random phases
      for (int p = 0; p < 10; p++) begin
         k = (p < 8) ? 3'(p) : 3'($urandom_range(0, 7));
         if (p == 9) quiet = 1;
         write_reg(REG_SLOPE, ($urandom_range(0, 3) == 0) ?
                   ($urandom_range(0, 1) ? 16'hffff : 16'h0000) : 16'($urandom));
         write_reg(REG_KIND, 16'(k));
         for (int i = 0; i < 15; i++) begin
            v = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 4095) - 2048)
                                            : 16'($urandom);
            send_word(v, (k == KIND_SOFTMAX) ? ($urandom_range(0, 3) == 0)
                                             : 1'($urandom));
            if (i == 12) drain();
         end
      end

      // full row with dropped words
      write_reg(REG_KIND, 16'(KIND_SOFTMAX));
      for (int i = 0; i < 66; i++)
         send_word(16'($urandom_range(0, 2047) - 1024), i == 65);
      quiet = 1;
      send_word(16'($urandom), 1'b1);

      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending_q.size() != 0);
      repeat (200) @(posedge clock);
      if (sb.errors == 0)
         $display("activation_function_unit verification clean");
      else
         $display("activation_function_unit verification failed");
      $finish;
   end
endmodule
`default_nettype wire

// ===== activation_function_unit.f =====
rtl/afu_pkg.sv
rtl/afu_mul.sv
rtl/afu_div.sv
rtl/afu_engine.sv
rtl/activation_function_unit.sv
rtl/afu_checker.sv
dv/tb_top.sv
